/* src/kcsd_pkg.sv */
// Shared types and constants of the key combination sequence detector.
// Depends on nothing; used by every module of the block.
`default_nettype none
package kcsd_pkg;

  localparam int unsigned CodeW     = 10;
  localparam int unsigned StateW    = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 8;

  localparam logic [CodeW-1:0] CodeUpRst    = 10'd115;
  localparam logic [CodeW-1:0] CodeDownRst  = 10'd114;
  localparam logic [CodeW-1:0] CodePowerRst = 10'd116;

  localparam logic [CfgIdxW-1:0] CfgDumpEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCodeUp     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCodeDown   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgCodePower  = 2'd3;

  typedef enum logic [StateW-1:0] {
    SEQ_IDLE      = 4'd0,
    SEQ_UP_P1     = 4'd1,
    SEQ_UP_R1     = 4'd2,
    SEQ_DOWN_P    = 4'd3,
    SEQ_DOWN_R    = 4'd4,
    SEQ_UP_P2     = 4'd5,
    SEQ_PWR_P1    = 4'd6,
    SEQ_PWR_R1    = 4'd7,
    SEQ_PWR_P2    = 4'd8,
    SEQ_PWR_R2    = 4'd9,
    SEQ_UP_R2     = 4'd10,
    SEQ_UP_P3     = 4'd11,
    SEQ_DEBUG     = 4'd12
  } seq_e;

  typedef struct packed {
    logic             dump_enable;
    logic [CodeW-1:0] code_up;
    logic [CodeW-1:0] code_down;
    logic [CodeW-1:0] code_power;
  } kcsd_cfg_t;

  typedef struct packed {
    logic              force_dump;
    logic              serial_request;
    logic [StateW-1:0] progress;
  } kcsd_res_t;

endpackage
`default_nettype wire

/* src/kcsd_cfg.sv */
// Configuration register file: dump enable and the three key codes.
// Depends on kcsd_pkg.
`default_nettype none
module kcsd_cfg
  import kcsd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               we_i,
  input  wire logic [CfgIdxW-1:0] idx_i,
  input  wire logic [CodeW-1:0]   data_i,
  output kcsd_cfg_t               cfg_o
);

  kcsd_cfg_t cfg_q;
  kcsd_cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        CfgDumpEnable: cfg_d.dump_enable = data_i[0];
        CfgCodeUp:     cfg_d.code_up     = data_i;
        CfgCodeDown:   cfg_d.code_down   = data_i;
        CfgCodePower:  cfg_d.code_power  = data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dump_enable <= 1'b0;
      cfg_q.code_up     <= CodeUpRst;
      cfg_q.code_down   <= CodeDownRst;
      cfg_q.code_power  <= CodePowerRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* src/kcsd_step.sv */
// Next-state and result logic of the detector for one key event.
// Depends on kcsd_pkg.
`default_nettype none
module kcsd_step
  import kcsd_pkg::*;
(
  input  wire kcsd_cfg_t          cfg_i,
  input  wire logic [StateW-1:0]  state_i,
  input  wire logic [CodeW-1:0]   key_code_i,
  input  wire logic               pressed_i,
  output kcsd_res_t               res_o
);

  logic up_p, up_r, down_p, down_r, pwr_p, pwr_r;
  seq_e nx;
  logic fd, sr;

  always_comb begin
    up_p   = (key_code_i == cfg_i.code_up)    &&  pressed_i;
    up_r   = (key_code_i == cfg_i.code_up)    && !pressed_i;
    down_p = (key_code_i == cfg_i.code_down)  &&  pressed_i;
    down_r = (key_code_i == cfg_i.code_down)  && !pressed_i;
    pwr_p  = (key_code_i == cfg_i.code_power) &&  pressed_i;
    pwr_r  = (key_code_i == cfg_i.code_power) && !pressed_i;
    fd = 1'b0;
    sr = 1'b0;
    nx = SEQ_IDLE;
    case (state_i)
      SEQ_UP_P1:  nx = up_r   ? SEQ_UP_R1  : SEQ_IDLE;
      SEQ_UP_R1:  nx = down_p ? SEQ_DOWN_P : SEQ_IDLE;
      SEQ_DOWN_P: nx = down_r ? SEQ_DOWN_R : SEQ_IDLE;
      SEQ_DOWN_R: nx = up_p   ? SEQ_UP_P2  : SEQ_IDLE;
      SEQ_UP_P2:  nx = pwr_p  ? SEQ_PWR_P1 : SEQ_IDLE;
      SEQ_PWR_P1: nx = pwr_r  ? SEQ_PWR_R1 : SEQ_IDLE;
      SEQ_PWR_R1: nx = pwr_p  ? SEQ_PWR_P2 : SEQ_IDLE;
      SEQ_PWR_P2: nx = pwr_r  ? SEQ_PWR_R2 : SEQ_IDLE;
      SEQ_PWR_R2: nx = up_r   ? SEQ_UP_R2  : SEQ_IDLE;
      SEQ_UP_R2: begin
        if (up_p) begin
          nx = SEQ_UP_P3;
        end else if (down_p) begin
          nx = SEQ_DEBUG;
        end else begin
          nx = SEQ_IDLE;
        end
      end
      SEQ_UP_P3: begin
        if (pwr_p) begin
          fd = cfg_i.dump_enable;
          nx = SEQ_UP_P3;
        end else begin
          nx = SEQ_IDLE;
        end
      end
      SEQ_DEBUG: begin
        sr = !pwr_p && down_r;
        nx = SEQ_IDLE;
      end
      default:    nx = up_p ? SEQ_UP_P1 : SEQ_IDLE;
    endcase
  end

  assign res_o.force_dump     = fd;
  assign res_o.serial_request = sr;
  assign res_o.progress       = nx;

endmodule
`default_nettype wire

/* src/key_combo_sequence_detector_core.sv */
// Datapath: an input transfer fills the input register, and its result the output register.
// Throughput: one key event per cycle while the master side takes results; the input
// register refills while a result waits in the output register.
// Reset: asynchronous, active low; detector returns to idle, both pipeline
// registers empty, dump enable cleared and key codes back to 115/114/116.
// Depends on kcsd_pkg, kcsd_cfg and kcsd_step.
`default_nettype none
module key_combo_sequence_detector_core
  import kcsd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CodeW-1:0]    cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // [9:0] key_code
  input  wire logic                s_axis_tuser,   // [0] pressed
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata    // [0] force_dump, [1] serial_request,
                                                   // [5:2] progress
);

  kcsd_cfg_t cfg;
  kcsd_res_t res;

  logic              in_vld_q;
  logic [CodeW-1:0]  code_q;
  logic              prs_q;
  logic [StateW-1:0] state_q;
  logic              out_vld_q;
  kcsd_res_t         out_q;
  logic              adv;
  logic              in_xfer;

  kcsd_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  kcsd_step u_step (
    .cfg_i      (cfg),
    .state_i    (state_q),
    .key_code_i (code_q),
    .pressed_i  (prs_q),
    .res_o      (res)
  );

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= SEQ_IDLE;
    end else begin
      if (in_xfer) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        state_q   <= res.progress;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      code_q <= s_axis_tdata[CodeW-1:0];
      prs_q  <= s_axis_tuser;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_q.progress, out_q.serial_request, out_q.force_dump};

endmodule
`default_nettype wire

/* src/kcsd_checker.sv */
// Port-level checks of the key combination sequence detector, bound to the top.
// Depends on kcsd_pkg and key_combo_sequence_detector_core.
`default_nettype none
module kcsd_checker
  import kcsd_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata
);

  logic [StateW-1:0] prog;
  assign prog = m_axis_tdata[StateW+1:2];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_dump_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> prog == SEQ_UP_P3)
    else $error("force_dump outside final step");

  a_serial_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> prog == SEQ_IDLE && !m_axis_tdata[0])
    else $error("serial_request with wrong state");

  a_prog_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> prog <= SEQ_DEBUG && m_axis_tdata[OutDataW-1:StateW+2] == '0)
    else $error("progress out of range");

endmodule

bind key_combo_sequence_detector_core kcsd_checker u_kcsd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

/* tb/tb.sv */
// Testbench for key_combo_sequence_detector_core: key events go in over the slave stream,
// a predictor tracks the combo state and each master-side transfer is checked per field.
// Depends on kcsd_pkg and the core RTL.
import kcsd_pkg::*;

class key_combo_predictor;
  kcsd_cfg_t cfg;
  seq_e      state;
  kcsd_res_t pending_results[$];
  int        mismatches;

  function new();
    cfg.dump_enable = 1'b0;
    cfg.code_up     = CodeUpRst;
    cfg.code_down   = CodeDownRst;
    cfg.code_power  = CodePowerRst;
    state           = SEQ_IDLE;
    mismatches      = 0;
  endfunction

  function void write_reg(logic [CfgIdxW-1:0] idx, logic [CodeW-1:0] data);
    case (idx)
      CfgDumpEnable: cfg.dump_enable = data[0];
      CfgCodeUp:     cfg.code_up     = data;
      CfgCodeDown:   cfg.code_down   = data;
      default:       cfg.code_power  = data;
    endcase
  endfunction

  function void note_event(logic [CodeW-1:0] code, logic prs);
    kcsd_res_t res;
    logic      up;
    logic      dn;
    logic      pw;
    up  = (code == cfg.code_up);
    dn  = (code == cfg.code_down);
    pw  = (code == cfg.code_power);
    res = '0;
    case (state)
      SEQ_UP_P1:  state = (up && !prs) ? SEQ_UP_R1 : SEQ_IDLE;
      SEQ_UP_R1:  state = (dn && prs) ? SEQ_DOWN_P : SEQ_IDLE;
      SEQ_DOWN_P: state = (dn && !prs) ? SEQ_DOWN_R : SEQ_IDLE;
      SEQ_DOWN_R: state = (up && prs) ? SEQ_UP_P2 : SEQ_IDLE;
      SEQ_UP_P2:  state = (pw && prs) ? SEQ_PWR_P1 : SEQ_IDLE;
      SEQ_PWR_P1: state = (pw && !prs) ? SEQ_PWR_R1 : SEQ_IDLE;
      SEQ_PWR_R1: state = (pw && prs) ? SEQ_PWR_P2 : SEQ_IDLE;
      SEQ_PWR_P2: state = (pw && !prs) ? SEQ_PWR_R2 : SEQ_IDLE;
      SEQ_PWR_R2: state = (up && !prs) ? SEQ_UP_R2 : SEQ_IDLE;
      SEQ_UP_R2: begin
        if (up && prs) state = SEQ_UP_P3;
        else if (dn && prs) state = SEQ_DEBUG;
        else state = SEQ_IDLE;
      end
      SEQ_UP_P3: begin
        if (pw && prs) res.force_dump = cfg.dump_enable;
        else state = SEQ_IDLE;
      end
      SEQ_DEBUG: begin
        res.serial_request = !(pw && prs) && dn && !prs;
        state = SEQ_IDLE;
      end
      default: state = (up && prs) ? SEQ_UP_P1 : SEQ_IDLE;
    endcase
    res.progress = state;
    pending_results.push_back(res);
  endfunction

  task flag_mismatch(string what);
    if (mismatches < 50) $display("mismatch: %s", what);
    mismatches++;
  endtask

  task check_result(logic [OutDataW-1:0] data);
    kcsd_res_t want;
    if (pending_results.size() == 0) begin
      flag_mismatch($sformatf("result 0x%02h with nothing expected", data));
      return;
    end
    want = pending_results.pop_front();
    if (data[0] !== want.force_dump)
      flag_mismatch($sformatf("force_dump %b, expected %b", data[0], want.force_dump));
    if (data[1] !== want.serial_request)
      flag_mismatch($sformatf("serial_request %b, expected %b", data[1], want.serial_request));
    if (data[5:2] !== want.progress)
      flag_mismatch($sformatf("progress %0d, expected %0d", data[5:2], want.progress));
  endtask

  task close_out();
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
  endtask
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {KEY_UP_SEL, KEY_DOWN_SEL, KEY_PWR_SEL} key_sel_e;

  localparam int StallLimit = 2000;
  localparam int HoldCycles = 300;
  localparam int PhaseItems = 110;
  localparam int NumPhases  = 10;
  localparam int PathLen    = 10;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CodeW-1:0]    cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // [9:0] key_code
  logic                s_axis_tuser = 1'b0; // [0] pressed
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // [0] force_dump, [1] serial_request,
                                            // [5:2] progress

  key_sel_e path_key [PathLen] = '{KEY_UP_SEL, KEY_UP_SEL, KEY_DOWN_SEL, KEY_DOWN_SEL,
                                   KEY_UP_SEL, KEY_PWR_SEL, KEY_PWR_SEL, KEY_PWR_SEL,
                                   KEY_PWR_SEL, KEY_UP_SEL};
  logic [PathLen-1:0] path_prs = 10'b0010110101;

  bit fast_mode = 1'b0;
  bit hold_req  = 1'b0;
  int items_sent = 0;
  int idle_cycles = 0;
  key_combo_predictor combo_model = new();

  key_combo_sequence_detector_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) combo_model.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        combo_model.note_event(s_axis_tdata[CodeW-1:0], s_axis_tuser);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int run;
    int stall;
    int r;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (fast_mode) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
        r = $urandom_range(0, 99);
        if (r < 80) stall = $urandom_range(1, 3);
        else if (r < 95) stall = $urandom_range(4, 10);
        else stall = $urandom_range(20, 50);
        m_axis_tready <= 1'b1;
        repeat (run) @(posedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  function automatic logic [CodeW-1:0] rand_code();
    return CodeW'($urandom_range(0, 767));
  endfunction

  function automatic logic [CodeW-1:0] code_of(key_sel_e k);
    case (k)
      KEY_UP_SEL:   return combo_model.cfg.code_up;
      KEY_DOWN_SEL: return combo_model.cfg.code_down;
      default:      return combo_model.cfg.code_power;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (fast_mode || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_event(logic [CodeW-1:0] code, logic prs);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'(code);
    s_axis_tuser  <= prs;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_key(key_sel_e k, logic prs);
    send_event(code_of(k), prs);
  endtask

  task automatic send_noise();
    send_event(rand_code(), 1'($urandom_range(0, 1)));
  endtask

  // break the path at step cut with a wrong press or a random key
  task automatic send_main_path(int cut, output bit done);
    for (int i = 0; i < PathLen; i++) begin
      if (i == cut) begin
        if ($urandom_range(0, 1)) send_key(path_key[i], !path_prs[i]);
        else send_noise();
        done = 1'b0;
        return;
      end
      send_key(path_key[i], path_prs[i]);
    end
    done = 1'b1;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (combo_model.pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apply_cfg(logic de, logic [CodeW-1:0] up, logic [CodeW-1:0] dn,
                           logic [CodeW-1:0] pw);
    logic [CfgIdxW-1:0] regs [4];
    logic [CodeW-1:0]   vals [4];
    regs = '{CfgDumpEnable, CfgCodeUp, CfgCodeDown, CfgCodePower};
    vals = '{{9'($urandom_range(0, 511)), de}, up, dn, pw};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      combo_model.write_reg(regs[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    bit               done;
    int               start;
    int               r;
    logic             de;
    logic [CodeW-1:0] up;
    logic [CodeW-1:0] dn;
    logic [CodeW-1:0] pw;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_event('0, 1'b1);
    send_event(10'd767, 1'b0);
    send_main_path(PathLen, done);
    send_key(KEY_DOWN_SEL, 1'b1);
    send_key(KEY_DOWN_SEL, 1'b0);
    drain();
    apply_cfg(1'b1, '0, 10'd767, 10'd512);
    send_main_path(PathLen, done);
    send_key(KEY_UP_SEL, 1'b1);
    send_key(KEY_PWR_SEL, 1'b1);
    send_key(KEY_PWR_SEL, 1'b1);
    send_key(KEY_PWR_SEL, 1'b0);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      de = (ph % 3 != 0);
      case (ph % 5)
        0: begin up = rand_code(); dn = rand_code(); pw = rand_code(); end
        1: begin up = 10'd767; dn = '0; pw = rand_code(); end
        2: begin up = rand_code(); dn = up; pw = up; end
        3: begin up = rand_code(); dn = rand_code(); pw = up; end
        default: begin up = CodeUpRst; dn = CodeDownRst; pw = CodePowerRst; end
      endcase
      apply_cfg(de, up, dn, pw);
      fast_mode = (ph == 2);
      if (ph == 5) hold_req = 1'b1;
      start = items_sent;
      while (items_sent - start < PhaseItems) begin
        if ($urandom_range(0, 99) < 70) begin
          send_main_path(($urandom_range(0, 3) == 0) ? $urandom_range(0, PathLen - 1)
                                                     : PathLen, done);
          if (done) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
              send_key(KEY_UP_SEL, 1'b1);
              repeat ($urandom_range(1, 3)) send_key(KEY_PWR_SEL, 1'b1);
              if ($urandom_range(0, 1)) send_noise();
            end else if (r < 85) begin
              send_key(KEY_DOWN_SEL, 1'b1);
              case ($urandom_range(0, 3))
                0, 1: send_key(KEY_DOWN_SEL, 1'b0);
                2:    send_key(KEY_PWR_SEL, 1'b1);
                default: send_noise();
              endcase
            end
          end
        end else begin
          repeat ($urandom_range(1, 4)) send_noise();
        end
      end
      fast_mode = 1'b0;
    end

    drain();
    combo_model.close_out();
    if (combo_model.mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
